// ===== rtl/fchb_pkg.sv =====
// Package for the four-channel H-bridge PWM driver.
// Holds command, direction and register codes and the channel item types.
// No dependencies.
package fchb_pkg;

  localparam int unsigned Channels = 4;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_SET4    = 3'd1,
    CMD_SET_LR  = 3'd2,
    CMD_ENABLE  = 3'd3,
    CMD_DISABLE = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    DIR_STOP    = 2'd0,
    DIR_FORWARD = 2'd1,
    DIR_REVERSE = 2'd2
  } dir_t;

  typedef enum logic [1:0] {
    CFG_REVERSED_MASK = 2'd0,
    CFG_PWM_PERIOD    = 2'd1,
    CFG_TICKS_PER_MS  = 2'd2
  } cfg_index_t;

  typedef struct packed {
    cmd_t                     cmd;
    logic signed [SpeedW-1:0] speed_a;
    logic signed [SpeedW-1:0] speed_b;
    logic signed [SpeedW-1:0] speed_c;
    logic signed [SpeedW-1:0] speed_d;
  } in_item_t;

  typedef struct packed {
    logic [Channels-1:0] in1_pins;
    logic [Channels-1:0] in2_pins;
    logic [Channels-1:0] pwm_pins;
    logic                standby_pin;
    logic                ms_pulse;
    logic [31:0]         ms_count;
  } out_item_t;

endpackage

// ===== rtl/fchb_if.sv =====
// Valid/ready channel interfaces for command and result transfers.
// Depends on fchb_pkg for the payload types.
interface fchb_in_if;
  logic               valid;
  logic               ready;
  fchb_pkg::in_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface fchb_out_if;
  logic                valid;
  logic                ready;
  fchb_pkg::out_item_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/four_channel_h_bridge_pwm_top.sv =====
// Four-channel H-bridge PWM driver: command decode, motor state and result register.
// Depends on fchb_pkg and the channel interfaces in fchb_if.sv.

// Each command transfer produces exactly one result transfer, registered in the
// cycle after the command is taken. The block takes one command every cycle:
// all work for a command is a single combinational pass (clamp, compare and
// counter increments) into the motor state and the result register, and the
// next command is taken in the same cycle that the pending result transfers,
// so the rate is one item per clock, limited only by result backpressure.
// Set commands clamp each speed to -100..100, negate it for channels whose
// reversed_mask bit is set, and derive direction pins and duty; a zero speed
// stops the channel and drops its PWM pin at once. Tick commands advance the
// millisecond prescaler (ms_pulse, ms_count) and the PWM counter, then refresh
// every PWM pin. Disable stops all channels and drops standby until enable.
// Configuration writes through cfg_we/cfg_index/cfg_data take effect on the
// next command; an index past the last register is ignored.
module four_channel_h_bridge_pwm_top (
  input  logic                           clk,
  input  logic                           rst,
  fchb_in_if.sink                        cmd_ch,
  fchb_out_if.source                     result_ch,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [fchb_pkg::CfgDataW-1:0]  cfg_data
);

  localparam int unsigned Ch = fchb_pkg::Channels;

  // Configuration registers.
  logic [Ch-1:0] reversed_mask;
  logic [7:0]    pwm_period;
  logic [15:0]   ticks_per_ms;

  // Motor and timing state.
  fchb_pkg::dir_t motor_dir [Ch];
  logic [6:0]     motor_duty [Ch];
  logic [Ch-1:0]  pwm_level;
  logic [7:0]     pwm_counter;
  logic [15:0]    ms_divider;
  logic [31:0]    ms_total;
  logic           driver_enabled;

  fchb_pkg::dir_t motor_dir_next [Ch];
  logic [6:0]     motor_duty_next [Ch];
  logic [Ch-1:0]  pwm_level_next;
  logic [7:0]     pwm_counter_next;
  logic [15:0]    ms_divider_next;
  logic [31:0]    ms_total_next;
  logic           driver_enabled_next;
  logic           ms_pulse_next;

  // Result register.
  logic                out_valid;
  fchb_pkg::out_item_t out_item;
  fchb_pkg::out_item_t out_item_next;

  logic cmd_xfer;

  // Take a command whenever the result slot is empty or drains this cycle.
  assign cmd_ch.ready = !out_valid || result_ch.ready;
  assign cmd_xfer     = cmd_ch.valid && cmd_ch.ready;

  assign result_ch.valid   = out_valid;
  assign result_ch.payload = out_item;

  // Clamp to +-100 and apply the reverse flag.
  function automatic logic signed [7:0] shape_speed(
    input logic signed [fchb_pkg::SpeedW-1:0] s,
    input logic                               rev
  );
    logic signed [7:0] v;
    if (s > 16'sd100) begin
      v = 8'sd100;
    end else if (s < -16'sd100) begin
      v = -8'sd100;
    end else begin
      v = s[7:0];
    end
    if (rev) begin
      v = -v;
    end
    return v;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      reversed_mask <= '0;
      pwm_period    <= 8'd100;
      ticks_per_ms  <= 16'd20;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fchb_pkg::CFG_REVERSED_MASK: reversed_mask <= cfg_data[Ch-1:0];
        fchb_pkg::CFG_PWM_PERIOD:    pwm_period    <= cfg_data[7:0];
        fchb_pkg::CFG_TICKS_PER_MS:  ticks_per_ms  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Next state and result for the command on the input channel.
  always_comb begin
    logic signed [fchb_pkg::SpeedW-1:0] raw [Ch];
    logic signed [7:0] shaped;
    logic signed [7:0] neg;
    logic [15:0]       div_inc;
    logic [7:0]        cnt_inc;
    logic              do_set;

    for (int i = 0; i < Ch; i++) begin
      motor_dir_next[i]  = motor_dir[i];
      motor_duty_next[i] = motor_duty[i];
    end
    pwm_level_next      = pwm_level;
    pwm_counter_next    = pwm_counter;
    ms_divider_next     = ms_divider;
    ms_total_next       = ms_total;
    driver_enabled_next = driver_enabled;
    ms_pulse_next       = 1'b0;
    do_set              = 1'b0;
    shaped              = '0;
    neg                 = '0;
    div_inc             = ms_divider + 16'd1;
    cnt_inc             = pwm_counter + 8'd1;

    // Speed routing; disable drives zero into every channel.
    raw[0] = cmd_ch.payload.speed_a;
    raw[1] = cmd_ch.payload.speed_b;
    raw[2] = cmd_ch.payload.speed_c;
    raw[3] = cmd_ch.payload.speed_d;

    unique case (cmd_ch.payload.cmd)
      fchb_pkg::CMD_TICK: begin
        if (div_inc >= ticks_per_ms) begin
          ms_divider_next = '0;
          ms_total_next   = ms_total + 32'd1;
          ms_pulse_next   = 1'b1;
        end else begin
          ms_divider_next = div_inc;
        end
        pwm_counter_next = (cnt_inc >= pwm_period) ? 8'd0 : cnt_inc;
        for (int i = 0; i < Ch; i++) begin
          pwm_level_next[i] = (motor_dir[i] != fchb_pkg::DIR_STOP) &&
                              ({1'b0, motor_duty[i]} > pwm_counter_next);
        end
      end
      fchb_pkg::CMD_SET4: begin
        do_set = 1'b1;
      end
      fchb_pkg::CMD_SET_LR: begin
        do_set = 1'b1;
        raw[0] = cmd_ch.payload.speed_b;
        raw[1] = cmd_ch.payload.speed_b;
        raw[2] = cmd_ch.payload.speed_a;
        raw[3] = cmd_ch.payload.speed_a;
      end
      fchb_pkg::CMD_ENABLE: begin
        driver_enabled_next = 1'b1;
      end
      fchb_pkg::CMD_DISABLE: begin
        do_set = 1'b1;
        driver_enabled_next = 1'b0;
        for (int i = 0; i < Ch; i++) begin
          raw[i] = '0;
        end
      end
      default: ;
    endcase

    if (do_set) begin
      for (int i = 0; i < Ch; i++) begin
        shaped = shape_speed(raw[i], reversed_mask[i]);
        neg    = -shaped;
        if (shaped > 8'sd0) begin
          motor_dir_next[i]  = fchb_pkg::DIR_FORWARD;
          motor_duty_next[i] = shaped[6:0];
        end else if (shaped < 8'sd0) begin
          motor_dir_next[i]  = fchb_pkg::DIR_REVERSE;
          motor_duty_next[i] = neg[6:0];
        end else begin
          // Stopped channel: force its PWM pin low now.
          motor_dir_next[i]  = fchb_pkg::DIR_STOP;
          motor_duty_next[i] = '0;
          pwm_level_next[i]  = 1'b0;
        end
      end
    end

    for (int i = 0; i < Ch; i++) begin
      out_item_next.in1_pins[i] = (motor_dir_next[i] == fchb_pkg::DIR_FORWARD);
      out_item_next.in2_pins[i] = (motor_dir_next[i] == fchb_pkg::DIR_REVERSE);
    end
    out_item_next.pwm_pins    = pwm_level_next;
    out_item_next.standby_pin = driver_enabled_next;
    out_item_next.ms_pulse    = ms_pulse_next;
    out_item_next.ms_count    = ms_total_next;
  end

  // Commit state on each command transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < Ch; i++) begin
        motor_dir[i]  <= fchb_pkg::DIR_STOP;
        motor_duty[i] <= '0;
      end
      pwm_level      <= '0;
      pwm_counter    <= '0;
      ms_divider     <= '0;
      ms_total       <= '0;
      driver_enabled <= 1'b1;
    end else if (cmd_xfer) begin
      for (int i = 0; i < Ch; i++) begin
        motor_dir[i]  <= motor_dir_next[i];
        motor_duty[i] <= motor_duty_next[i];
      end
      pwm_level      <= pwm_level_next;
      pwm_counter    <= pwm_counter_next;
      ms_divider     <= ms_divider_next;
      ms_total       <= ms_total_next;
      driver_enabled <= driver_enabled_next;
    end
  end

  // Result slot: fill on command transfer, drain on result transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_xfer) begin
      out_valid <= 1'b1;
    end else if (result_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_xfer) begin
      out_item <= out_item_next;
    end
  end

endmodule

// ===== rtl/fchb_checker.sv =====
// Port-level checks for the four-channel H-bridge PWM driver.
// Depends on fchb_pkg; bound to four_channel_h_bridge_pwm_top below.
module fchb_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input fchb_pkg::out_item_t out_item
);

  // A stalled result holds.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed while stalled");

  // Every command transfer yields a result next cycle.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> out_valid)
    else $error("command transfer without result");

  // A channel never drives both direction pins.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.in1_pins & out_item.in2_pins) == '0)
    else $error("channel driven forward and reverse");

  // PWM only on a channel with a direction.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |->
      (out_item.pwm_pins & ~(out_item.in1_pins | out_item.in2_pins)) == '0)
    else $error("PWM high on stopped channel");

endmodule

bind four_channel_h_bridge_pwm_top fchb_checker u_fchb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (cmd_ch.valid),
  .in_ready  (cmd_ch.ready),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .out_item  (result_ch.payload)
);

// ===== tb/four_channel_h_bridge_pwm_top_tb.sv =====
// Self-checking testbench for the four-channel H-bridge PWM driver.
// Drives command transfers, predicts every result transfer and compares pins.
// Depends on fchb_pkg, fchb_if.sv and four_channel_h_bridge_pwm_top.
`timescale 1ns / 1ps

module four_channel_h_bridge_pwm_top_tb;

  // Long enough for every item waiting out the longest sender gap and the
  // longest receiver stall, plus the one long hold-off.
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned LongHoldCycles = 300;
  localparam int unsigned LongHoldAfter = 400;
  localparam int unsigned ItemsPerPhase = 165;
  localparam int unsigned RandomPhases = 10;
  localparam int unsigned CfgDataW = fchb_pkg::CfgDataW;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  fchb_in_if cmd_ch ();
  fchb_out_if result_ch ();

  four_channel_h_bridge_pwm_top u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_ch    (cmd_ch),
    .result_ch (result_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Motor state predictor: its own copy of channel state and registers.
  // ---------------------------------------------------------------------------
  fchb_pkg::dir_t chan_dir [fchb_pkg::Channels];
  logic [6:0]     chan_duty [fchb_pkg::Channels];
  logic [3:0]     pwm_bits;
  logic [7:0]     pwm_phase;
  logic [15:0]    ms_prescale;
  logic [31:0]    ms_elapsed;
  logic           standby_on;
  logic [3:0]     rev_mask;
  logic [7:0]     period_ticks;
  logic [15:0]    ms_ticks;

  // Clamp to +/-100, flip for reversed channels, then split into direction
  // and duty. A stopped channel drops its PWM bit right away.
  function automatic void apply_speed(int ch, logic signed [15:0] raw);
    int s;
    int mag;
    s = raw;
    if (s > 100) s = 100;
    if (s < -100) s = -100;
    if (rev_mask[ch]) s = -s;
    mag = (s < 0) ? -s : s;
    if (s > 0) begin
      chan_dir[ch] = fchb_pkg::DIR_FORWARD;
      chan_duty[ch] = mag[6:0];
    end else if (s < 0) begin
      chan_dir[ch] = fchb_pkg::DIR_REVERSE;
      chan_duty[ch] = mag[6:0];
    end else begin
      chan_dir[ch] = fchb_pkg::DIR_STOP;
      chan_duty[ch] = '0;
      pwm_bits[ch] = 1'b0;
    end
  endfunction

  // Advance the model by one command and return the pins it reports.
  function automatic fchb_pkg::out_item_t next_pin_state(fchb_pkg::in_item_t it);
    fchb_pkg::out_item_t res;
    logic pulse;
    int i;
    pulse = 1'b0;
    case (it.cmd)
      fchb_pkg::CMD_TICK: begin
        ms_prescale = ms_prescale + 16'd1;
        if (ms_prescale >= ms_ticks) begin
          ms_prescale = '0;
          ms_elapsed = ms_elapsed + 32'd1;
          pulse = 1'b1;
        end
        pwm_phase = pwm_phase + 8'd1;
        if (pwm_phase >= period_ticks) pwm_phase = '0;
        pwm_bits = '0;
        for (i = 0; i < fchb_pkg::Channels; i++) begin
          if (chan_dir[i] != fchb_pkg::DIR_STOP && {1'b0, chan_duty[i]} > pwm_phase)
            pwm_bits[i] = 1'b1;
        end
      end
      fchb_pkg::CMD_SET4: begin
        apply_speed(0, it.speed_a);
        apply_speed(1, it.speed_b);
        apply_speed(2, it.speed_c);
        apply_speed(3, it.speed_d);
      end
      fchb_pkg::CMD_SET_LR: begin
        // right side drives channels 1 and 2, left side channels 3 and 4
        apply_speed(0, it.speed_b);
        apply_speed(1, it.speed_b);
        apply_speed(2, it.speed_a);
        apply_speed(3, it.speed_a);
      end
      fchb_pkg::CMD_ENABLE: standby_on = 1'b1;
      fchb_pkg::CMD_DISABLE: begin
        for (i = 0; i < fchb_pkg::Channels; i++) apply_speed(i, 16'sd0);
        standby_on = 1'b0;
      end
      default: ;  // unknown codes leave everything as it is
    endcase
    res = '0;
    for (i = 0; i < fchb_pkg::Channels; i++) begin
      if (chan_dir[i] == fchb_pkg::DIR_FORWARD) res.in1_pins[i] = 1'b1;
      else if (chan_dir[i] == fchb_pkg::DIR_REVERSE) res.in2_pins[i] = 1'b1;
    end
    res.pwm_pins = pwm_bits;
    res.standby_pin = standby_on;
    res.ms_pulse = pulse;
    res.ms_count = ms_elapsed;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Command backlog, expected pins and bookkeeping.
  // ---------------------------------------------------------------------------
  fchb_pkg::in_item_t  cmd_backlog [$];
  fchb_pkg::out_item_t pin_forecast [$];
  int unsigned items_queued;
  int unsigned items_accepted;
  int unsigned results_seen;
  int unsigned cycles;
  logic        failed;
  logic        idle_enabled;  // phases are gappy, but every third one is back-to-back
  logic        cmd_taken;
  int unsigned send_gap;
  int unsigned hold_left;
  logic        long_hold_done;

  // Mostly short gaps, now and then a long one; none at all in calm phases.
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (!idle_enabled) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Speeds cluster around the clamp limits and zero, with some full-range noise.
  function automatic logic signed [15:0] random_speed();
    int v;
    case ($urandom_range(0, 9))
      0, 1: v = 0;
      2: v = int'($urandom);
      3: begin
        v = $urandom_range(99, 101);
        if ($urandom_range(0, 1) != 0) v = -v;
      end
      default: v = int'($urandom_range(0, 200)) - 100;
    endcase
    return 16'(v);
  endfunction

  task automatic queue_cmd(fchb_pkg::cmd_t op, int a, int b, int c, int d);
    fchb_pkg::in_item_t it;
    it.cmd = op;
    it.speed_a = 16'(a);
    it.speed_b = 16'(b);
    it.speed_c = 16'(c);
    it.speed_d = 16'(d);
    cmd_backlog.push_back(it);
    items_queued++;
  endtask

  // Ticks dominate so the PWM and millisecond logic stays busy; the rest is a
  // mix of speed updates, enable/disable and unknown codes.
  task automatic queue_random(int unsigned count);
    fchb_pkg::in_item_t it;
    int unsigned r;
    repeat (count) begin
      r = $urandom_range(0, 99);
      it.speed_a = random_speed();
      it.speed_b = random_speed();
      it.speed_c = random_speed();
      it.speed_d = random_speed();
      if (r < 50) it.cmd = fchb_pkg::CMD_TICK;
      else if (r < 67) it.cmd = fchb_pkg::CMD_SET4;
      else if (r < 79) it.cmd = fchb_pkg::CMD_SET_LR;
      else if (r < 86) it.cmd = fchb_pkg::CMD_ENABLE;
      else if (r < 92) it.cmd = fchb_pkg::CMD_DISABLE;
      else it.cmd = fchb_pkg::cmd_t'($urandom_range(5, 7));
      cmd_backlog.push_back(it);
      items_queued++;
    end
  endtask

  // Write one register at a falling edge and mirror it in the predictor once
  // the rising edge has taken it.
  task automatic write_reg(fchb_pkg::cfg_index_t idx, logic [CfgDataW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fchb_pkg::CFG_REVERSED_MASK: rev_mask = val[3:0];
      fchb_pkg::CFG_PWM_PERIOD: period_ticks = val[7:0];
      fchb_pkg::CFG_TICKS_PER_MS: ms_ticks = val;
      default: ;
    endcase
  endtask

  task automatic set_regs(int unsigned mask, int unsigned period, int unsigned tpm);
    write_reg(fchb_pkg::CFG_REVERSED_MASK, CfgDataW'(mask));
    write_reg(fchb_pkg::CFG_PWM_PERIOD, CfgDataW'(period));
    write_reg(fchb_pkg::CFG_TICKS_PER_MS, CfgDataW'(tpm));
  endtask

  // Hold until every queued command has transferred and every result is back.
  task automatic drain();
    while (items_accepted != items_queued || pin_forecast.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      failed = 1'b1;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Command driver: change inputs on the falling edge only.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (cmd_ch.valid && !cmd_taken) begin
      // hold the offered command until it transfers
    end else if (send_gap > 0) begin
      send_gap <= send_gap - 1;
      cmd_ch.valid <= 1'b0;
    end else if (cmd_backlog.size() > 0) begin
      cmd_ch.payload <= cmd_backlog.pop_front();
      cmd_ch.valid <= 1'b1;
      send_gap <= pick_gap();
    end else begin
      cmd_ch.valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off while the driver
  // keeps offering, so the block fills up and stalls its command input.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else if (!long_hold_done && results_seen >= LongHoldAfter) begin
      hold_left <= LongHoldCycles;
      long_hold_done <= 1'b1;
      result_ch.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= 1'b1;
      hold_left <= pick_gap();
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both channels on the rising edge. Check the result first,
  // then predict the command taken at this same edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    fchb_pkg::out_item_t want;
    fchb_pkg::out_item_t got;
    cmd_taken <= !rst && cmd_ch.valid && cmd_ch.ready;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got = result_ch.payload;
      results_seen++;
      if (pin_forecast.size() == 0) begin
        $display("%0t: result transfer with none expected, expected none, actual 0x%0h",
                 $time, got);
        failed = 1'b1;
      end else begin
        want = pin_forecast.pop_front();
        check_field("in1_pins", 32'(want.in1_pins), 32'(got.in1_pins));
        check_field("in2_pins", 32'(want.in2_pins), 32'(got.in2_pins));
        check_field("pwm_pins", 32'(want.pwm_pins), 32'(got.pwm_pins));
        check_field("standby_pin", 32'(want.standby_pin), 32'(got.standby_pin));
        check_field("ms_pulse", 32'(want.ms_pulse), 32'(got.ms_pulse));
        check_field("ms_count", want.ms_count, got.ms_count);
      end
    end
    if (!rst && cmd_ch.valid && cmd_ch.ready) begin
      pin_forecast.push_back(next_pin_state(cmd_ch.payload));
      items_accepted++;
    end
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed phase, then random phases under varied settings.
  // ---------------------------------------------------------------------------
  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = fchb_pkg::CFG_REVERSED_MASK;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.payload = '0;
    result_ch.ready = 1'b0;
    items_queued = 0;
    items_accepted = 0;
    results_seen = 0;
    cycles = 0;
    failed = 1'b0;
    idle_enabled = 1'b1;
    cmd_taken = 1'b0;
    send_gap = 0;
    hold_left = 0;
    long_hold_done = 1'b0;
    for (int i = 0; i < fchb_pkg::Channels; i++) begin
      chan_dir[i] = fchb_pkg::DIR_STOP;
      chan_duty[i] = '0;
    end
    pwm_bits = '0;
    pwm_phase = '0;
    ms_prescale = '0;
    ms_elapsed = '0;
    standby_on = 1'b1;
    rev_mask = 4'd0;
    period_ticks = 8'd100;
    ms_ticks = 16'd20;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: reset settings written back explicitly, then the field
    // extremes, clamp edges, every command and the special cases.
    set_regs(0, 100, 20);
    queue_cmd(fchb_pkg::CMD_TICK, 0, 0, 0, 0);
    queue_cmd(fchb_pkg::CMD_SET4, 32767, -32768, 0, 100);
    queue_cmd(fchb_pkg::CMD_TICK, 0, 0, 0, 0);
    queue_cmd(fchb_pkg::CMD_TICK, 0, 0, 0, 0);
    queue_cmd(fchb_pkg::CMD_SET4, -100, 101, -101, 1);
    queue_cmd(fchb_pkg::CMD_TICK, 0, 0, 0, 0);
    queue_cmd(fchb_pkg::CMD_SET4, -1, 99, -99, 0);
    queue_cmd(fchb_pkg::CMD_SET_LR, -32768, 32767, 0, 0);
    queue_cmd(fchb_pkg::CMD_TICK, 0, 0, 0, 0);
    // zero speed on a running channel drops its PWM pin before the next tick
    queue_cmd(fchb_pkg::CMD_SET_LR, 0, 50, 0, 0);
    queue_cmd(fchb_pkg::CMD_SET4, 60, -60, 30, -30);
    queue_cmd(fchb_pkg::CMD_TICK, 0, 0, 0, 0);
    queue_cmd(fchb_pkg::CMD_SET4, 0, 0, 0, 0);
    queue_cmd(fchb_pkg::CMD_TICK, 0, 0, 0, 0);
    // disable stops everything; later sets still land while standby stays low
    queue_cmd(fchb_pkg::CMD_SET4, 80, -80, 80, -80);
    queue_cmd(fchb_pkg::CMD_DISABLE, 12, 34, 56, 78);
    queue_cmd(fchb_pkg::CMD_SET4, 80, 80, -80, -80);
    queue_cmd(fchb_pkg::CMD_TICK, 0, 0, 0, 0);
    queue_cmd(fchb_pkg::CMD_ENABLE, 0, 0, 0, 0);
    queue_cmd(fchb_pkg::cmd_t'(5), 21845, -21846, 1, -1);
    queue_cmd(fchb_pkg::cmd_t'(6), -21846, 21845, -1, 1);
    queue_cmd(fchb_pkg::cmd_t'(7), 32767, -32768, 32767, -32768);
    queue_cmd(fchb_pkg::CMD_TICK, -32768, 32767, -32768, 32767);
    drain();

    // Random phases. The first few pin the extremes: both mask extremes,
    // period 1 and 255, the largest ms threshold followed by a lowered one
    // (prescaler above threshold), then zero period and zero threshold.
    for (int p = 0; p < RandomPhases; p++) begin
      idle_enabled = (p % 3) != 2;
      case (p)
        0: set_regs(15, 1, 1);
        1: set_regs(5, 255, 65535);
        2: set_regs(10, 7, 3);
        3: set_regs(0, 0, 0);
        default: set_regs($urandom_range(0, 15), $urandom_range(1, 255), $urandom_range(1, 40));
      endcase
      queue_random(ItemsPerPhase);
      drain();
    end

    // Let any stray result show up before the verdict.
    repeat (8) @(posedge clk);
    if (pin_forecast.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pin_forecast.size());
      failed = 1'b1;
    end
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
